FILE: rtl/window_peak_valley_gap_defines.svh
// assertion macros for the window peak valley gap block
`ifndef WINDOW_PEAK_VALLEY_GAP_DEFINES_SVH
`define WINDOW_PEAK_VALLEY_GAP_DEFINES_SVH
// property that holds after reset
`define WPVG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked also during reset
`define WPVG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/wpvg_pkg.sv
// shared types and constants for the window peak valley gap block
`default_nettype none
package wpvg_pkg;
  localparam int WINDOW_DEF     = 256;
  localparam int LIST_DEPTH_DEF = 128;
  localparam int VAL_W          = 18;
  localparam int GAP_W          = 27;
  localparam int COEF_W         = 16;
  localparam int SAMPLE_W       = 16;
  localparam int TOP_W          = 8;
  localparam int ACC_W          = 35;
  localparam int SUM_W          = 32;
  localparam int REG_IDX_W      = 2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Z = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd3;
  localparam logic signed [GAP_W-1:0] GAP_MAX = 27'sd50331647;
  localparam logic signed [GAP_W-1:0] GAP_MIN = -27'sd50331648;

  typedef enum logic [1:0] {
    LOP_INSERT,
    LOP_REMOVE
  } list_op_t;

  // request from the sequencer to one list engine
  typedef struct packed {
    logic     start;
    list_op_t op;
  } list_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PROJ1, S_PROJ2, S_PROJ3, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_RD5,
    S_CLS_OUT, S_WAIT_OUT, S_CLS_IN, S_WAIT_IN, S_WRITE, S_SUM, S_WAIT_SUM,
    S_DIV, S_WAIT_DIV, S_RESULT, S_HOLD
  } seq_state_t;

  typedef enum logic [2:0] {
    L_IDLE, L_SCAN, L_SHIFT_RD, L_SHIFT_WR, L_SUM_RD, L_SUM_ACC, L_DONE
  } list_state_t;
endpackage
`default_nettype wire

FILE: rtl/wpvg_list.sv
// sorted extremum list in one memory with insert, remove and top-k sum
`default_nettype none
`include "window_peak_valley_gap_defines.svh"
module wpvg_list #(
  parameter int LIST_DEPTH = wpvg_pkg::LIST_DEPTH_DEF,
  parameter bit FROM_TOP   = 1'b1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wpvg_pkg::list_req_t req,
  input  wire logic signed [wpvg_pkg::VAL_W-1:0] value,
  input  wire logic sum_start,
  input  wire logic [wpvg_pkg::TOP_W-1:0] k_req,
  output logic busy,
  output logic [$clog2(LIST_DEPTH+1)-1:0] total,
  output logic [$clog2(LIST_DEPTH+1)-1:0] k_used,
  output logic signed [wpvg_pkg::SUM_W-1:0] sum
);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH+1);

  logic signed [wpvg_pkg::VAL_W-1:0] mem [LIST_DEPTH];
  logic signed [wpvg_pkg::VAL_W-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic signed [wpvg_pkg::VAL_W-1:0] wr_data;

  wpvg_pkg::list_state_t st_r, st_nxt;
  wpvg_pkg::list_op_t op_r, op_nxt;
  logic signed [wpvg_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0] total_r, total_nxt, idx_r, idx_nxt, pos_r, pos_nxt, kcnt_r, kcnt_nxt;
  logic signed [wpvg_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0] kc;

  // memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wpvg_pkg::L_IDLE;
      total_r <= '0;
    end else begin
      st_r <= st_nxt;
      total_r <= total_nxt;
    end
    op_r <= op_nxt; val_r <= val_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt;
    kcnt_r <= kcnt_nxt; sum_r <= sum_nxt;
  end

  // clamp requested k to list size, zero reads as one
  always_comb begin
    kc = total_r;
    if (k_req == '0) begin
      if (total_r != '0) kc = CW'(1);
    end else if (32'(k_req) < 32'(total_r)) begin
      kc = CW'(k_req);
    end
  end

  // scan, shift and summing sequencer
  always_comb begin
    st_nxt = st_r; op_nxt = op_r; val_nxt = val_r; total_nxt = total_r;
    idx_nxt = idx_r; pos_nxt = pos_r; kcnt_nxt = kcnt_r; sum_nxt = sum_r;
    rd_addr = idx_r[AW-1:0]; wr_en = 1'b0; wr_addr = pos_r[AW-1:0]; wr_data = val_r;
    case (st_r)
      wpvg_pkg::L_IDLE: begin
        if (req.start) begin
          op_nxt = req.op; val_nxt = value; idx_nxt = '0;
          if (req.op == wpvg_pkg::LOP_INSERT && total_r == CW'(LIST_DEPTH))
            st_nxt = wpvg_pkg::L_DONE;
          else if (total_r == '0) begin
            if (req.op == wpvg_pkg::LOP_INSERT) begin
              wr_en = 1'b1; wr_addr = '0; wr_data = value; total_nxt = CW'(1);
            end
            st_nxt = wpvg_pkg::L_DONE;
          end else begin
            rd_addr = '0; idx_nxt = CW'(1); pos_nxt = '0; st_nxt = wpvg_pkg::L_SCAN;
          end
        end else if (sum_start) begin
          kcnt_nxt = kc; sum_nxt = '0; pos_nxt = '0;
          if (kc == '0) st_nxt = wpvg_pkg::L_DONE;
          else begin
            rd_addr = FROM_TOP ? AW'(total_r - CW'(1)) : '0;
            st_nxt = wpvg_pkg::L_SUM_ACC;
          end
        end
      end
      wpvg_pkg::L_SCAN: begin
        // rd_q holds entry pos_r
        if ((op_r == wpvg_pkg::LOP_INSERT && !(rd_q < val_r)) ||
            (op_r == wpvg_pkg::LOP_REMOVE && rd_q == val_r)) begin
          if (op_r == wpvg_pkg::LOP_INSERT) begin
            idx_nxt = total_r; st_nxt = wpvg_pkg::L_SHIFT_RD;
          end else begin
            idx_nxt = pos_r + CW'(1); st_nxt = wpvg_pkg::L_SHIFT_RD;
          end
        end else if (pos_r + CW'(1) == total_r) begin
          if (op_r == wpvg_pkg::LOP_INSERT) begin
            wr_en = 1'b1; wr_addr = AW'(total_r); total_nxt = total_r + CW'(1);
          end
          st_nxt = wpvg_pkg::L_DONE;
        end else begin
          pos_nxt = pos_r + CW'(1); rd_addr = idx_r[AW-1:0]; idx_nxt = idx_r + CW'(1);
        end
      end
      wpvg_pkg::L_SHIFT_RD: begin
        if (op_r == wpvg_pkg::LOP_INSERT) begin
          if (idx_r == pos_r) begin
            wr_en = 1'b1; total_nxt = total_r + CW'(1); st_nxt = wpvg_pkg::L_DONE;
          end else begin
            rd_addr = AW'(idx_r - CW'(1)); st_nxt = wpvg_pkg::L_SHIFT_WR;
          end
        end else begin
          if (idx_r == total_r) begin
            total_nxt = total_r - CW'(1); st_nxt = wpvg_pkg::L_DONE;
          end else begin
            rd_addr = idx_r[AW-1:0]; st_nxt = wpvg_pkg::L_SHIFT_WR;
          end
        end
      end
      wpvg_pkg::L_SHIFT_WR: begin
        wr_en = 1'b1; wr_data = rd_q;
        if (op_r == wpvg_pkg::LOP_INSERT) begin
          wr_addr = idx_r[AW-1:0]; idx_nxt = idx_r - CW'(1);
        end else begin
          wr_addr = AW'(idx_r - CW'(1)); idx_nxt = idx_r + CW'(1);
        end
        st_nxt = wpvg_pkg::L_SHIFT_RD;
      end
      // one entry a cycle, the next read lands while this one is added
      wpvg_pkg::L_SUM_ACC: begin
        sum_nxt = sum_r + wpvg_pkg::SUM_W'(rd_q);
        pos_nxt = pos_r + CW'(1);
        if (pos_r + CW'(1) == kcnt_r) st_nxt = wpvg_pkg::L_DONE;
        else begin
          rd_addr = FROM_TOP ? AW'(total_r - CW'(2) - pos_r) : AW'(pos_r + CW'(1));
          st_nxt = wpvg_pkg::L_SUM_ACC;
        end
      end
      wpvg_pkg::L_SUM_RD: st_nxt = wpvg_pkg::L_SUM_ACC;
      wpvg_pkg::L_DONE: st_nxt = wpvg_pkg::L_IDLE;
      default: st_nxt = wpvg_pkg::L_IDLE;
    endcase
  end

  assign busy   = (st_r != wpvg_pkg::L_IDLE) || req.start || sum_start;
  assign total  = total_r;
  assign k_used = kcnt_r;
  assign sum    = sum_r;

  `WPVG_ASSERT(a_total_bound, total_r <= CW'(LIST_DEPTH), "list count beyond depth")
  `WPVG_ASSERT(a_total_step, (total_r != $past(total_r)) |-> (total_r == $past(total_r) + CW'(1) || total_r == $past(total_r) - CW'(1)), "list count jumped")
  `WPVG_ASSERT(a_no_req_busy, (st_r != wpvg_pkg::L_IDLE) |-> !req.start, "request while busy")
endmodule
`default_nettype wire

FILE: rtl/wpvg_div.sv
// restoring divider for the signed floor mean of a list sum, scaled by 256
`default_nettype none
module wpvg_div #(
  parameter int KW = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [wpvg_pkg::SUM_W-1:0] sum,
  input  wire logic [KW-1:0] k,
  output logic busy,
  output logic signed [wpvg_pkg::SUM_W+8:0] quot
);
  localparam int NW = wpvg_pkg::SUM_W + 8;
  localparam int CW = $clog2(NW+1);
  logic [NW-1:0] num_r, num_nxt, q_r, q_nxt;
  logic [KW:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt, run_r, run_nxt;
  logic signed [NW:0] n_ext;
  logic [KW:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else run_r <= run_nxt;
    num_r <= num_nxt; q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt;
  end

  // one quotient bit a cycle on the magnitude
  always_comb begin
    num_nxt = num_r; q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; run_nxt = run_r;
    n_ext = {sum[wpvg_pkg::SUM_W-1], sum, 8'd0};
    trial = {rem_r[KW-1:0], num_r[NW-1]};
    if (start) begin
      neg_nxt = n_ext[NW];
      num_nxt = n_ext[NW] ? NW'(-n_ext) : NW'(n_ext);
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(NW); run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, k}) begin
        rem_nxt = trial - {1'b0, k}; q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial; q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  assign busy = run_r || start;
  // floor for negative: -(q + (rem != 0))
  assign quot = neg_r ? -$signed({1'b0, q_r} + (NW+1)'(rem_r != '0)) : $signed({1'b0, q_r});
endmodule
`default_nettype wire

FILE: rtl/wpvg_seq.sv
// window memory, projection and per-sample sequencer
`default_nettype none
`include "window_peak_valley_gap_defines.svh"
module wpvg_seq #(
  parameter int WINDOW = wpvg_pkg::WINDOW_DEF,
  parameter int LIST_DEPTH = wpvg_pkg::LIST_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [wpvg_pkg::SAMPLE_W-1:0] sx,
  input  wire logic signed [wpvg_pkg::SAMPLE_W-1:0] sy,
  input  wire logic signed [wpvg_pkg::SAMPLE_W-1:0] sz,
  input  wire logic signed [wpvg_pkg::COEF_W-1:0] cx,
  input  wire logic signed [wpvg_pkg::COEF_W-1:0] cy,
  input  wire logic signed [wpvg_pkg::COEF_W-1:0] cz,
  input  wire logic [wpvg_pkg::TOP_W-1:0] top,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [wpvg_pkg::GAP_W-1:0] gap,
  output logic no_ext
);
  localparam int AW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW+1);
  localparam int CW = $clog2(LIST_DEPTH+1);
  localparam int QW = wpvg_pkg::SUM_W + 9;

  logic signed [wpvg_pkg::VAL_W-1:0] wmem [WINDOW];
  logic signed [wpvg_pkg::VAL_W-1:0] wq;
  logic [AW-1:0] wra, wwa; logic wwe;

  wpvg_pkg::seq_state_t st_r, st_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic signed [wpvg_pkg::SAMPLE_W-1:0] sx_r, sy_r, sz_r;
  logic signed [wpvg_pkg::ACC_W-1:0] acc_r, acc_nxt, prod;
  logic signed [wpvg_pkg::SAMPLE_W-1:0] pa; logic signed [wpvg_pkg::COEF_W-1:0] pb;
  logic signed [wpvg_pkg::VAL_W-1:0] v_r, v_nxt;
  logic signed [wpvg_pkg::VAL_W-1:0] t0_r, t1_r, t2_r, t3_r, t4_r;
  logic signed [wpvg_pkg::VAL_W-1:0] t0_n, t1_n, t2_n, t3_n, t4_n;
  logic signed [QW-1:0] qp_r, qp_nxt;
  logic signed [QW-1:0] g_full;
  logic signed [wpvg_pkg::GAP_W-1:0] gap_r, gap_nxt;
  logic noext_r, noext_nxt;
  logic signed [wpvg_pkg::VAL_W-1:0] ca, cb, cc;
  logic pk, vl, add;
  wpvg_pkg::list_req_t preq, vreq;
  logic sum_go, pbusy, vbusy, dstart, dbusy, dsel_r, dsel_nxt;
  logic [CW-1:0] ptot, vtot, pk_used, vk_used;
  logic signed [wpvg_pkg::SUM_W-1:0] psum, vsum;
  logic signed [QW-1:0] dq;

  // window address plus an offset below WINDOW, wrapped into the window
  function automatic logic [AW-1:0] wadd(input logic [AW-1:0] a, input logic [AW:0] d);
    logic [AW:0] s;
    s = {1'b0, a} + d;
    if (s >= (AW+1)'(WINDOW)) s = s - (AW+1)'(WINDOW);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wwe) wmem[wwa] <= v_r;
    wq <= wmem[wra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wpvg_pkg::S_IDLE; fill_r <= '0; wp_r <= '0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; wp_r <= wp_nxt;
    end
    if (in_valid && in_ready) begin sx_r <= sx; sy_r <= sy; sz_r <= sz; end
    acc_r <= acc_nxt; v_r <= v_nxt; qp_r <= qp_nxt; gap_r <= gap_nxt; noext_r <= noext_nxt;
    t0_r <= t0_n; t1_r <= t1_n; t2_r <= t2_n; t3_r <= t3_n; t4_r <= t4_n; dsel_r <= dsel_nxt;
  end

  // one shared multiplier for the three axis products
  always_comb begin
    case (st_r)
      wpvg_pkg::S_PROJ1: begin pa = sx_r; pb = cx; end
      wpvg_pkg::S_PROJ2: begin pa = sy_r; pb = cy; end
      default:           begin pa = sz_r; pb = cz; end
    endcase
    prod = wpvg_pkg::ACC_W'(pa) * wpvg_pkg::ACC_W'(pb);
  end

  wpvg_list #(.LIST_DEPTH(LIST_DEPTH), .FROM_TOP(1'b1)) u_peak (
    .clk, .rst_n, .req(preq), .value(cb), .sum_start(sum_go), .k_req(top),
    .busy(pbusy), .total(ptot), .k_used(pk_used), .sum(psum));
  wpvg_list #(.LIST_DEPTH(LIST_DEPTH), .FROM_TOP(1'b0)) u_valley (
    .clk, .rst_n, .req(vreq), .value(cb), .sum_start(sum_go), .k_req(top),
    .busy(vbusy), .total(vtot), .k_used(vk_used), .sum(vsum));
  wpvg_div #(.KW(CW)) u_div (
    .clk, .rst_n, .start(dstart), .sum(dsel_r ? vsum : psum),
    .k(dsel_r ? vk_used : pk_used), .busy(dbusy), .quot(dq));

  assign g_full = qp_r - dq;

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; wp_nxt = wp_r; acc_nxt = acc_r; v_nxt = v_r;
    qp_nxt = qp_r; gap_nxt = gap_r; noext_nxt = noext_r;
    t0_n = t0_r; t1_n = t1_r; t2_n = t2_r; t3_n = t3_r; t4_n = t4_r; dsel_nxt = dsel_r;
    wra = wp_r; wwa = wp_r; wwe = 1'b0;
    ca = t0_r; cb = t1_r; cc = t2_r; add = 1'b0; pk = 1'b0; vl = 1'b0;
    preq = '{start: 1'b0, op: wpvg_pkg::LOP_INSERT};
    vreq = '{start: 1'b0, op: wpvg_pkg::LOP_INSERT};
    sum_go = 1'b0; dstart = 1'b0;
    case (st_r)
      wpvg_pkg::S_IDLE: if (in_valid) st_nxt = wpvg_pkg::S_PROJ1;
      wpvg_pkg::S_PROJ1: begin acc_nxt = prod; st_nxt = wpvg_pkg::S_PROJ2; end
      wpvg_pkg::S_PROJ2: begin acc_nxt = acc_r + prod; st_nxt = wpvg_pkg::S_PROJ3; end
      wpvg_pkg::S_PROJ3: begin
        acc_nxt = acc_r + prod;
        st_nxt = wpvg_pkg::S_RD0;
      end
      // round half up, then read the neighbors
      wpvg_pkg::S_RD0: begin
        v_nxt = wpvg_pkg::VAL_W'((acc_r + wpvg_pkg::ACC_W'(16384)) >>> 15);
        wra = wp_r; st_nxt = wpvg_pkg::S_RD1;
      end
      wpvg_pkg::S_RD1: begin
        wra = wadd(wp_r, (AW+1)'(1)); t0_n = wq; st_nxt = wpvg_pkg::S_RD2;
      end
      wpvg_pkg::S_RD2: begin
        wra = wadd(wp_r, (AW+1)'(2)); t1_n = wq; st_nxt = wpvg_pkg::S_RD3;
      end
      wpvg_pkg::S_RD3: begin
        wra = wadd(wp_r, (AW+1)'(WINDOW-2)); t2_n = wq; st_nxt = wpvg_pkg::S_RD4;
      end
      wpvg_pkg::S_RD4: begin
        wra = wadd(wp_r, (AW+1)'(WINDOW-1)); t3_n = wq; st_nxt = wpvg_pkg::S_RD5;
      end
      wpvg_pkg::S_RD5: begin
        t4_n = wq;
        st_nxt = (fill_r == FW'(WINDOW)) ? wpvg_pkg::S_CLS_OUT : wpvg_pkg::S_CLS_IN;
      end
      wpvg_pkg::S_CLS_OUT: begin
        pk = (t1_r > t0_r) && (t1_r > t2_r); vl = (t1_r < t0_r) && (t1_r < t2_r);
        preq = '{start: pk, op: wpvg_pkg::LOP_REMOVE};
        vreq = '{start: vl, op: wpvg_pkg::LOP_REMOVE};
        st_nxt = wpvg_pkg::S_WAIT_OUT;
      end
      wpvg_pkg::S_WAIT_OUT: if (!pbusy && !vbusy) st_nxt = wpvg_pkg::S_CLS_IN;
      wpvg_pkg::S_CLS_IN: begin
        ca = t3_r; cb = t4_r; cc = v_r;
        add = (fill_r >= FW'(2));
        pk = add && (cb > ca) && (cb > cc); vl = add && (cb < ca) && (cb < cc);
        preq = '{start: pk, op: wpvg_pkg::LOP_INSERT};
        vreq = '{start: vl, op: wpvg_pkg::LOP_INSERT};
        st_nxt = wpvg_pkg::S_WAIT_IN;
      end
      wpvg_pkg::S_WAIT_IN: begin
        ca = t3_r; cb = t4_r; cc = v_r;
        if (!pbusy && !vbusy) st_nxt = wpvg_pkg::S_WRITE;
      end
      wpvg_pkg::S_WRITE: begin
        wwe = 1'b1; wwa = wp_r; wp_nxt = wadd(wp_r, (AW+1)'(1));
        if (fill_r != FW'(WINDOW)) fill_nxt = fill_r + FW'(1);
        if (fill_r + FW'(1) < FW'(WINDOW)) st_nxt = wpvg_pkg::S_IDLE;
        else if (ptot == '0 || vtot == '0) begin
          gap_nxt = '0; noext_nxt = 1'b1; st_nxt = wpvg_pkg::S_HOLD;
        end else st_nxt = wpvg_pkg::S_SUM;
      end
      wpvg_pkg::S_SUM: begin sum_go = 1'b1; st_nxt = wpvg_pkg::S_WAIT_SUM; end
      wpvg_pkg::S_WAIT_SUM: if (!pbusy && !vbusy) begin
        dsel_nxt = 1'b0; st_nxt = wpvg_pkg::S_DIV;
      end
      wpvg_pkg::S_DIV: begin dstart = 1'b1; st_nxt = wpvg_pkg::S_WAIT_DIV; end
      wpvg_pkg::S_WAIT_DIV: if (!dbusy) begin
        if (!dsel_r) begin
          qp_nxt = dq; dsel_nxt = 1'b1; st_nxt = wpvg_pkg::S_DIV;
        end else st_nxt = wpvg_pkg::S_RESULT;
      end
      // saturate and present
      wpvg_pkg::S_RESULT: begin
        noext_nxt = 1'b0;
        if (g_full > QW'(wpvg_pkg::GAP_MAX)) gap_nxt = wpvg_pkg::GAP_MAX;
        else if (g_full < QW'(wpvg_pkg::GAP_MIN)) gap_nxt = wpvg_pkg::GAP_MIN;
        else gap_nxt = wpvg_pkg::GAP_W'(g_full);
        st_nxt = wpvg_pkg::S_HOLD;
      end
      wpvg_pkg::S_HOLD: if (out_ready) st_nxt = wpvg_pkg::S_IDLE;
      default: st_nxt = wpvg_pkg::S_IDLE;
    endcase
  end

  assign in_ready  = (st_r == wpvg_pkg::S_IDLE);
  assign out_valid = (st_r == wpvg_pkg::S_HOLD);
  assign gap       = gap_r;
  assign no_ext    = noext_r;

  `WPVG_ASSERT(a_fill_bound, fill_r <= FW'(WINDOW), "fill beyond window")
  `WPVG_ASSERT(a_noext_gap, out_valid && no_ext |-> gap == '0, "gap not zero on empty list")
  `WPVG_ASSERT(a_out_needs_full, out_valid |-> fill_r == FW'(WINDOW), "result before window full")
  `WPVG_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> st_r == wpvg_pkg::S_IDLE, "not idle after reset")
endmodule
`default_nettype wire

FILE: rtl/window_peak_valley_gap.sv
// each sample passes through the projection, the neighbor reads and the list scans and shifts;
// with a full window and both lists non-empty, a top-k sum per list and two divides follow
// one sample at a time: a new sample is taken only after the last one is done and its
// result, if any, accepted; the shift loops, list sums and the divider bound the sample rate
// no result until WINDOW samples have arrived; then one result per sample
// synchronous active-low reset clears counters and control; memories are left as they are
`default_nettype none
module window_peak_valley_gap #(
  parameter int WINDOW = wpvg_pkg::WINDOW_DEF,
  parameter int LIST_DEPTH = wpvg_pkg::LIST_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [47:0] in_tdata,   // sample_x, sample_y, sample_z
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [31:0] out_tdata,       // gap, no_extrema, zero fill
  input  wire logic cfg_we,
  input  wire logic [wpvg_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic [7:0] top_r;
  logic signed [wpvg_pkg::GAP_W-1:0] gap;
  logic no_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 16'sd32767; cy_r <= '0; cz_r <= '0; top_r <= 8'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        wpvg_pkg::REG_COEF_X: cx_r <= cfg_data;
        wpvg_pkg::REG_COEF_Y: cy_r <= cfg_data;
        wpvg_pkg::REG_COEF_Z: cz_r <= cfg_data;
        wpvg_pkg::REG_TOP:    top_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  wpvg_seq #(.WINDOW(WINDOW), .LIST_DEPTH(LIST_DEPTH)) u_seq (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .sx(in_tdata[15:0]), .sy(in_tdata[31:16]), .sz(in_tdata[47:32]),
    .cx(cx_r), .cy(cy_r), .cz(cz_r), .top(top_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .gap(gap), .no_ext(no_ext));

  assign out_tdata = {4'd0, no_ext, gap};
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the window peak valley gap block: scoreboard class, drivers and checks
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int WIN = 256;
  localparam int LDEPTH = 128;

  // projected-gap predictor with its own window and sorted extrema lists
  class gap_scoreboard;
    int win_vals[WIN];
    int peaks[$];
    int valleys[$];
    int fill;
    int wptr;
    int cx, cy, cz;
    int unsigned topk;
    logic [27:0] gap_q[$];
    int errors;
    int results_seen;
    int flagged_seen;

    function void clear();
      peaks.delete();
      valleys.delete();
      gap_q.delete();
      fill = 0;
      wptr = 0;
      cx = 32767;
      cy = 0;
      cz = 0;
      topk = 25;
      errors = 0;
      results_seen = 0;
      flagged_seen = 0;
    endfunction

    function void write_reg(logic [wpvg_pkg::REG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        wpvg_pkg::REG_COEF_X: cx = $signed(val);
        wpvg_pkg::REG_COEF_Y: cy = $signed(val);
        wpvg_pkg::REG_COEF_Z: cz = $signed(val);
        wpvg_pkg::REG_TOP: topk = val[7:0];
        default: ;
      endcase
    endfunction

    function void sorted_add(ref int lst[$], input int v);
      int pos;
      pos = 0;
      if (lst.size() >= LDEPTH) return;
      while (pos < lst.size() && lst[pos] < v) pos++;
      lst.insert(pos, v);
    endfunction

    function void sorted_drop(ref int lst[$], input int v);
      foreach (lst[i]) begin
        if (lst[i] == v) begin
          lst.delete(i);
          return;
        end
      end
    endfunction

    function void extremum(int a, int b, int c, bit add);
      if (b > a && b > c) begin
        if (add) sorted_add(peaks, b);
        else sorted_drop(peaks, b);
      end
      if (b < a && b < c) begin
        if (add) sorted_add(valleys, b);
        else sorted_drop(valleys, b);
      end
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    // note an accepted sample and queue the gap it yields, if any
    function void note_sample(logic [47:0] d);
      longint acc, g, sp, sv;
      int v, k, kp, kv;
      acc = longint'($signed(d[15:0])) * cx + longint'($signed(d[31:16])) * cy
          + longint'($signed(d[47:32])) * cz;
      v = int'(fdiv(acc + 16384, 32768));
      if (fill < WIN) begin
        if (fill >= 2) extremum(win_vals[fill-2], win_vals[fill-1], v, 1);
        win_vals[wptr] = v;
        fill++;
        wptr = (wptr + 1) % WIN;
        if (fill < WIN) return;
      end else begin
        extremum(win_vals[wptr], win_vals[(wptr+1)%WIN], win_vals[(wptr+2)%WIN], 0);
        extremum(win_vals[(wptr+WIN-2)%WIN], win_vals[(wptr+WIN-1)%WIN], v, 1);
        win_vals[wptr] = v;
        wptr = (wptr + 1) % WIN;
      end
      if (peaks.size() == 0 || valleys.size() == 0) begin
        gap_q.push_back({1'b1, 27'd0});
        return;
      end
      k = (topk == 0) ? 1 : topk;
      kp = (k < peaks.size()) ? k : peaks.size();
      kv = (k < valleys.size()) ? k : valleys.size();
      sp = 0;
      sv = 0;
      for (int i = 0; i < kp; i++) sp += peaks[peaks.size()-1-i];
      for (int i = 0; i < kv; i++) sv += valleys[i];
      g = fdiv(sp * 256, kp) - fdiv(sv * 256, kv);
      if (g > 50331647) g = 50331647;
      if (g < -50331648) g = -50331648;
      gap_q.push_back({1'b0, g[26:0]});
    endfunction

    // compare one result beat against the oldest expected gap, flag and fill bits
    function void check_gap(logic [31:0] d);
      logic [27:0] e;
      if (gap_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, d);
        errors++;
        return;
      end
      e = gap_q.pop_front();
      results_seen++;
      if (e[27]) flagged_seen++;
      if (d[26:0] !== e[26:0]) begin
        $display("%0t: gap mismatch, expected %0d actual %0d", $time,
                 $signed(e[26:0]), $signed(d[26:0]));
        errors++;
      end
      if (d[27] !== e[27]) begin
        $display("%0t: no_extrema mismatch, expected %0b actual %0b", $time, e[27], d[27]);
        errors++;
      end
      if (d[31:28] !== 4'd0) begin
        $display("%0t: fill bits mismatch, expected 0 actual %h", $time, d[31:28]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [wpvg_pkg::REG_IDX_W-1:0] cfg_index = wpvg_pkg::REG_COEF_X;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 27;
  int recv_idle_pct = 58;
  int samples_sent = 0;
  gap_scoreboard sb;

  always #5 clk = ~clk;

  window_peak_valley_gap DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stalls, check each accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_gap(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // send one sample beat, with a random gap before it
  task automatic send_sample(logic [47:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(d);
    samples_sent++;
  endtask

  // hold off until every expected gap has come, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.gap_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [wpvg_pkg::REG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [7:0] t);
    write_reg(wpvg_pkg::REG_COEF_X, x);
    write_reg(wpvg_pkg::REG_COEF_Y, y);
    write_reg(wpvg_pkg::REG_COEF_Z, z);
    write_reg(wpvg_pkg::REG_TOP, {8'd0, t});
    cfg_we <= 1'b0;
  endtask

  // random sample: mostly small values, some full-range noise
  function automatic logic [47:0] rand_sample(int mode);
    logic [47:0] d;
    d = 48'({$urandom, $urandom});
    if (mode == 1) begin
      d[15:0] = 16'($signed($urandom_range(200)) - 100);
      d[31:16] = 16'($signed($urandom_range(200)) - 100);
      d[47:32] = 16'($signed($urandom_range(8)) - 4);
    end
    return d;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample($urandom_range(3) != 0));
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes while the window fills at reset settings
    send_sample({16'h7fff, 16'h7fff, 16'h7fff});
    send_sample({16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h0000, 16'h0000, 16'h7fff});
    send_sample({16'h0000, 16'h0000, 16'h8000});
    send_sample('0);
    send_sample('0);
    send_sample({16'h0000, 16'h0000, 16'hffff});
    send_sample({16'h0000, 16'h0000, 16'h0001});
    send_sample({16'h0000, 16'h0000, 16'h7fff});
    send_sample({16'h0000, 16'h0000, 16'h7fff});
    send_sample({16'h0000, 16'h0000, 16'h8000});
    // flat stretch: equal values are no extrema
    for (int i = 0; i < 12; i++) send_sample({16'h0, 16'h0, 16'h1234});
    drain();

    // gap just below the saturation limit: all coefficients at the extremes, top_count zero
    set_all(16'h8000, 16'h8000, 16'h8000, 8'd0);
    send_idle_pct = 27;
    recv_idle_pct = 58;
    for (int i = 0; i < 300; i++)
      send_sample(i[0] ? {16'h8000, 16'h8000, 16'h8000} : {16'h7fff, 16'h7fff, 16'h7fff});
    drain();

    // many extrema and top_count 128, so the sums take whole lists
    set_all(16'h7fff, 16'h4000, 16'h0001, 8'd128);
    random_run(500);
    drain();

    send_idle_pct = 58;
    recv_idle_pct = 27;
    set_all(16'h1234, 16'hc000, 16'h7fff, 8'd1);
    random_run(450);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_all(16'(($urandom)), 16'($urandom), 16'($urandom), 8'd255);
    random_run(350);
    drain();
    set_all(16'h0000, 16'h0000, 16'h0000, 8'd7);
    random_run(260);
    drain();

    $display("covered %0d samples, %0d gap beats, %0d with empty extrema lists",
             samples_sent, sb.results_seen, sb.flagged_seen);
    $display("register settings included coefficient and top-count extremes");
    if (sb.errors == 0 && sb.gap_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run-time limit
  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/wpvg_pkg.sv
rtl/wpvg_list.sv
rtl/wpvg_div.sv
rtl/wpvg_seq.sv
rtl/window_peak_valley_gap.sv
test/tb_top.sv
